### sv/sltd_pkg.sv
package sltd_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TAIL1   = 3'd5,
    PH_TAIL2   = 3'd6
  } phase_t;

  // Event kinds reported at frame end
  typedef enum logic [2:0] {
    EV_READY_ACK = 3'd0,
    EV_XFER_DONE = 3'd1,
    EV_CANCEL    = 3'd2,
    EV_OTHER     = 3'd3,
    EV_BAD_TAIL  = 3'd4
  } event_kind_t;

  // Frame type codes
  localparam logic [7:0] TYPE_READY_ACK = 8'h01;
  localparam logic [7:0] TYPE_XFER_DONE = 8'h03;
  localparam logic [7:0] TYPE_CANCEL    = 8'h04;
  localparam logic [7:0] SUCCESS_BYTE   = 8'h01;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_WORD = 2'd0;
  localparam logic [1:0] REG_TAIL_WORD = 2'd1;

  localparam logic [31:0] SYNC_WORD_RESET = 32'h0FF0_00FF;
  localparam logic [15:0] TAIL_WORD_RESET = 16'h0D0A;

  typedef struct packed {
    event_kind_t kind;
    logic        success;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
  } frame_event_t;

endpackage

### sv/sltd_parser.sv
module sltd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  input  logic [7:0]            rx_byte,
  input  logic [31:0]           sync_word,
  input  logic [15:0]           tail_word,
  output logic                  evt_valid,
  output sltd_pkg::frame_event_t evt
);

  sltd_pkg::phase_t phase, phase_next;
  logic [23:0] recent_bytes, recent_bytes_next;
  logic [1:0]  fill_count, fill_count_next;
  logic [15:0] length_value, length_value_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  type_value, type_value_next;
  logic [7:0]  first_after_type, first_after_type_next;
  logic [7:0]  tail_first_seen, tail_first_seen_next;

  logic [31:0] window;
  logic [15:0] bytes_left_dec;
  logic [15:0] tail_seen;

  assign window         = {recent_bytes, rx_byte};
  assign bytes_left_dec = bytes_left - 16'd1;
  assign tail_seen      = {tail_first_seen, rx_byte};

  // Next-state and datapath update for one accepted byte
  always_comb begin
    phase_next            = phase;
    recent_bytes_next     = recent_bytes;
    fill_count_next       = fill_count;
    length_value_next     = length_value;
    bytes_left_next       = bytes_left;
    type_value_next       = type_value;
    first_after_type_next = first_after_type;
    tail_first_seen_next  = tail_first_seen;
    if (byte_valid) begin
      case (phase)
        sltd_pkg::PH_HUNT: begin
          if (fill_count == 2'd3 && window == sync_word) begin
            phase_next = sltd_pkg::PH_LEN_HI;
          end else begin
            recent_bytes_next = window[23:0];
            if (fill_count != 2'd3) fill_count_next = fill_count + 2'd1;
          end
        end
        sltd_pkg::PH_LEN_HI: begin
          length_value_next = {rx_byte, 8'h00};
          phase_next        = sltd_pkg::PH_LEN_LO;
        end
        sltd_pkg::PH_LEN_LO: begin
          length_value_next = {length_value[15:8], rx_byte};
          bytes_left_next   = {length_value[15:8], rx_byte};
          phase_next        = sltd_pkg::PH_TYPE;
        end
        sltd_pkg::PH_TYPE: begin
          type_value_next = rx_byte;
          phase_next = (length_value != 16'd0) ? sltd_pkg::PH_PAYLOAD : sltd_pkg::PH_TAIL1;
        end
        sltd_pkg::PH_PAYLOAD: begin
          if (bytes_left == length_value) first_after_type_next = rx_byte;
          bytes_left_next = bytes_left_dec;
          if (bytes_left_dec == 16'd0) phase_next = sltd_pkg::PH_TAIL1;
        end
        sltd_pkg::PH_TAIL1: begin
          // empty payload: success is judged on the first tail byte
          if (length_value == 16'd0) first_after_type_next = rx_byte;
          tail_first_seen_next = rx_byte;
          phase_next           = sltd_pkg::PH_TAIL2;
        end
        default: begin
          // end of frame (or an unused code): restart with an empty window
          phase_next        = sltd_pkg::PH_HUNT;
          recent_bytes_next = 24'd0;
          fill_count_next   = 2'd0;
        end
      endcase
    end
  end

  // Event produced on the second tail byte
  always_comb begin
    evt_valid          = byte_valid && (phase == sltd_pkg::PH_TAIL2);
    evt.frame_type     = type_value;
    evt.payload_length = length_value;
    if (tail_seen != tail_word) begin
      evt.kind = sltd_pkg::EV_BAD_TAIL;
    end else begin
      case (type_value)
        sltd_pkg::TYPE_READY_ACK: evt.kind = sltd_pkg::EV_READY_ACK;
        sltd_pkg::TYPE_XFER_DONE: evt.kind = sltd_pkg::EV_XFER_DONE;
        sltd_pkg::TYPE_CANCEL:    evt.kind = sltd_pkg::EV_CANCEL;
        default:                  evt.kind = sltd_pkg::EV_OTHER;
      endcase
    end
    evt.success = (evt.kind == sltd_pkg::EV_XFER_DONE) &&
                  (first_after_type == sltd_pkg::SUCCESS_BYTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= sltd_pkg::PH_HUNT;
      recent_bytes     <= 24'd0;
      fill_count       <= 2'd0;
      length_value     <= 16'd0;
      bytes_left       <= 16'd0;
      type_value       <= 8'd0;
      first_after_type <= 8'd0;
      tail_first_seen  <= 8'd0;
    end else begin
      phase            <= phase_next;
      recent_bytes     <= recent_bytes_next;
      fill_count       <= fill_count_next;
      length_value     <= length_value_next;
      bytes_left       <= bytes_left_next;
      type_value       <= type_value_next;
      first_after_type <= first_after_type_next;
      tail_first_seen  <= tail_first_seen_next;
    end
  end

endmodule

### sv/sltd_out_buf.sv
module sltd_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sltd_pkg::frame_event_t push_evt,
  output logic                   can_push,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sltd_pkg::frame_event_t out_evt
);

  // Two-entry queue: one request may land while the head waits downstream
  sltd_pkg::frame_event_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign can_push  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_evt   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/sync_length_tail_deframer_top.sv
// Result timing: a result request appears on the master side in the cycle after the
//   second tail byte of a frame is accepted.
// Throughput: one byte per cycle; the input stalls only when two results wait
//   unclaimed in the two-entry output queue.
// Reset (rst, synchronous, active high): parser back to sync hunting with an
//   empty window, output queue emptied, sync_word and tail_word to defaults.
module sync_length_tail_deframer_top (
  input  logic        clk,
  input  logic        rst,
  // slave side: received byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // master side: frame events
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] success, [8:1] frame_type,
                                      // [24:9] payload_length, [31:25] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] sync_word;
  logic [15:0] tail_word;

  logic                   byte_accept;
  logic                   evt_valid;
  logic                   can_push;
  sltd_pkg::frame_event_t evt;
  sltd_pkg::frame_event_t out_evt;

  // Config registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= sltd_pkg::SYNC_WORD_RESET;
      tail_word <= sltd_pkg::TAIL_WORD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sltd_pkg::REG_SYNC_WORD: sync_word <= cfg_data;
        sltd_pkg::REG_TAIL_WORD: tail_word <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Byte taken whenever the queue has room for a possible result.
  assign s_axis_tready = can_push;
  assign byte_accept   = s_axis_tvalid && s_axis_tready;

  sltd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_accept),
    .rx_byte   (s_axis_tdata),
    .sync_word (sync_word),
    .tail_word (tail_word),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  sltd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (evt_valid),
    .push_evt (evt),
    .can_push (can_push),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_evt  (out_evt)
  );

  assign m_axis_tuser = out_evt.kind;
  assign m_axis_tdata = {7'd0, out_evt.payload_length, out_evt.frame_type, out_evt.success};

endmodule

### sv/sltd_checker.sv
module sltd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // a stalled result request holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // success only accompanies transfer done
  a_success: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != sltd_pkg::EV_XFER_DONE |-> !m_axis_tdata[0])
    else $error("success flag on wrong kind");

  // ready ack carries type 0x01
  a_ack_type: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == sltd_pkg::EV_READY_ACK |->
    m_axis_tdata[8:1] == sltd_pkg::TYPE_READY_ACK)
    else $error("ready ack with wrong type");

  // transfer done and cancel carry their type codes
  a_done_type: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == sltd_pkg::EV_XFER_DONE ||
    m_axis_tuser == sltd_pkg::EV_CANCEL) |->
    (m_axis_tdata[8:1] == sltd_pkg::TYPE_XFER_DONE ||
    m_axis_tdata[8:1] == sltd_pkg::TYPE_CANCEL))
    else $error("done/cancel with wrong type");

endmodule

bind sync_length_tail_deframer_top sltd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

### tb/sltd_frame_checker.sv
`timescale 1ns / 1ps

module sltd_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [0] success, [8:1] frame_type,
                                      // [24:9] payload_length, [31:25] zero
  input  logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          outstanding,
  output int          fail_count
);

  logic [31:0]            sync_reg;
  logic [15:0]            tail_reg;
  sltd_pkg::phase_t       ph;
  logic [23:0]            hist;
  int                     hist_cnt;
  logic [15:0]            frame_len;
  logic [15:0]            remaining;
  logic [7:0]             ftype;
  logic [7:0]             lead_byte;
  logic [7:0]             tail_hi;
  sltd_pkg::frame_event_t due_events[$];
  int                     errors = 0;

  task automatic report(input string msg);
    $display("%0t sltd_frame_checker: %s", $time, msg);
    errors++;
  endtask

  task automatic restart_hunt();
    ph = sltd_pkg::PH_HUNT;
    hist = '0;
    hist_cnt = 0;
  endtask

  // one received byte through the parser; a frame end queues its event
  task automatic deframe_byte(input logic [7:0] b);
    logic [31:0]            win;
    sltd_pkg::frame_event_t ev;
    win = {hist, b};
    case (ph)
      sltd_pkg::PH_HUNT: begin
        if (hist_cnt >= 3 && win == sync_reg) begin
          ph = sltd_pkg::PH_LEN_HI;
        end else begin
          hist = win[23:0];
          if (hist_cnt < 3) hist_cnt++;
        end
      end
      sltd_pkg::PH_LEN_HI: begin
        frame_len = {b, 8'h00};
        ph = sltd_pkg::PH_LEN_LO;
      end
      sltd_pkg::PH_LEN_LO: begin
        frame_len[7:0] = b;
        remaining = frame_len;
        ph = sltd_pkg::PH_TYPE;
      end
      sltd_pkg::PH_TYPE: begin
        ftype = b;
        ph = (frame_len != 16'd0) ? sltd_pkg::PH_PAYLOAD : sltd_pkg::PH_TAIL1;
      end
      sltd_pkg::PH_PAYLOAD: begin
        if (remaining == frame_len) lead_byte = b;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) ph = sltd_pkg::PH_TAIL1;
      end
      sltd_pkg::PH_TAIL1: begin
        // empty payload: the first tail byte doubles as the success byte
        if (frame_len == 16'd0) lead_byte = b;
        tail_hi = b;
        ph = sltd_pkg::PH_TAIL2;
      end
      sltd_pkg::PH_TAIL2: begin
        ev.frame_type = ftype;
        ev.payload_length = frame_len;
        if ({tail_hi, b} != tail_reg) begin
          ev.kind = sltd_pkg::EV_BAD_TAIL;
        end else begin
          case (ftype)
            sltd_pkg::TYPE_READY_ACK: ev.kind = sltd_pkg::EV_READY_ACK;
            sltd_pkg::TYPE_XFER_DONE: ev.kind = sltd_pkg::EV_XFER_DONE;
            sltd_pkg::TYPE_CANCEL:    ev.kind = sltd_pkg::EV_CANCEL;
            default:                  ev.kind = sltd_pkg::EV_OTHER;
          endcase
        end
        ev.success = (ev.kind == sltd_pkg::EV_XFER_DONE) &&
                     (lead_byte == sltd_pkg::SUCCESS_BYTE);
        due_events.push_back(ev);
        restart_hunt();
      end
      default: restart_hunt();
    endcase
  endtask

  task automatic check_event();
    sltd_pkg::frame_event_t want;
    if (due_events.size() == 0) begin
      report($sformatf("unexpected event kind=%0d type=%02h len=%0d", m_axis_tuser,
                       m_axis_tdata[8:1], m_axis_tdata[24:9]));
    end else begin
      want = due_events.pop_front();
      if (m_axis_tuser !== want.kind)
        report($sformatf("event_kind %0d, want %0d", m_axis_tuser, want.kind));
      if (m_axis_tdata[0] !== want.success)
        report($sformatf("success %b, want %b", m_axis_tdata[0], want.success));
      if (m_axis_tdata[8:1] !== want.frame_type)
        report($sformatf("frame_type %02h, want %02h", m_axis_tdata[8:1],
                         want.frame_type));
      if (m_axis_tdata[24:9] !== want.payload_length)
        report($sformatf("payload_length %0d, want %0d", m_axis_tdata[24:9],
                         want.payload_length));
      if (m_axis_tdata[31:25] !== 7'd0)
        report($sformatf("pad bits %b, want zero", m_axis_tdata[31:25]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sync_reg = sltd_pkg::SYNC_WORD_RESET;
      tail_reg = sltd_pkg::TAIL_WORD_RESET;
      restart_hunt();
      frame_len = '0;
      remaining = '0;
      ftype = '0;
      lead_byte = '0;
      tail_hi = '0;
      due_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sltd_pkg::REG_SYNC_WORD: sync_reg = cfg_data;
          sltd_pkg::REG_TAIL_WORD: tail_reg = cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_event();
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
    end
    outstanding <= due_events.size();
    fail_count <= errors;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // cycles with no request, event or register write before we call it hung
  localparam int STALL_LIMIT = 5000;
  // indexes past the register list; writes there must be ignored
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;       // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [0] success, [8:1] frame_type,
                                        // [24:9] payload_length, [31:25] zero
  logic [2:0]  m_axis_tuser;            // [2:0] event_kind
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int outstanding;
  int fail_count;

  // register values as the stimulus believes them to be
  logic [31:0] cur_sync = sltd_pkg::SYNC_WORD_RESET;
  logic [15:0] cur_tail = sltd_pkg::TAIL_WORD_RESET;

  int         burst_left = 0;
  int         bytes_sent = 0;
  int         idle_cycles = 0;
  rx_mode_t   rx_mode = RX_FREE;
  int         rx_left = 0;
  logic [7:0] cyc = '0;

  sync_length_tail_deframer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sltd_frame_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Event sink: tready follows a mode that is picked at random and held for a while.
  // Free-running stretches alternate with coin flips, rare grants (which
  // fill the output queue and push back on the byte stream) and a fixed
  // 1-in-4 pattern.
  always @(posedge clk) begin
    cyc <= cyc + 8'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:   m_axis_tready <= (cyc[3:2] == 2'b00);
    endcase
  end

  // Watchdog: any request, event or register write resets the count.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // One byte request. Bytes go out in bursts; a burst that runs out is
  // followed by a random gap (sometimes none), so gaps land on every parser
  // phase. Returns at the edge where the byte was taken, tvalid still high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Register write with the parser quiet: stop the byte stream, let every
  // pending event drain, give the output queue time to settle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sltd_pkg::REG_SYNC_WORD: cur_sync = val;
      sltd_pkg::REG_TAIL_WORD: cur_tail = val[15:0];
      default: ;
    endcase
  endtask

  // sync word, big-endian length, type, payload (first byte = lead)
  task automatic send_head(input logic [31:0] sw, input logic [7:0] ft,
                           input logic [15:0] len, input logic [7:0] lead);
    for (int i = 3; i >= 0; i--) send_byte(sw[8*i +: 8]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(ft);
    for (int i = 0; i < int'(len); i++) send_byte((i == 0) ? lead : 8'($urandom));
  endtask

  task automatic send_tail(input logic [15:0] tw);
    send_byte(tw[15:8]);
    send_byte(tw[7:0]);
  endtask

  task automatic send_frame(input logic [31:0] sw, input logic [7:0] ft,
                            input logic [15:0] len, input logic [7:0] lead,
                            input logic [15:0] tw);
    send_head(sw, ft, len, lead);
    send_tail(tw);
  endtask

  // Mostly well-formed frames with random content; the rest is line noise,
  // sync words cut short and damaged tails.
  task automatic random_frames(input int n);
    int          stop_at;
    int          k;
    logic [7:0]  ft;
    logic [7:0]  lead;
    logic [15:0] len;
    logic [15:0] tw;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        2: begin
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) send_byte(cur_sync[31 - 8*i -: 8]);
        end
        default: ;
      endcase
      case ($urandom_range(0, 4))
        0:       ft = sltd_pkg::TYPE_READY_ACK;
        1:       ft = sltd_pkg::TYPE_XFER_DONE;
        2:       ft = sltd_pkg::TYPE_CANCEL;
        default: ft = 8'($urandom);
      endcase
      // short payloads mostly, now and then a longer one
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 48))
                                        : 16'($urandom_range(0, 6));
      lead = ($urandom_range(0, 1) == 0) ? sltd_pkg::SUCCESS_BYTE : 8'($urandom);
      case ($urandom_range(0, 9))
        0:       tw = 16'($urandom);
        1:       tw = cur_tail ^ (16'd1 << $urandom_range(0, 15));
        default: tw = cur_tail;
      endcase
      send_frame(cur_sync, ft, len, lead, tw);
    end
  endtask

  initial begin
    logic [31:0] sw;
    logic [15:0] tw;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset register values ---
    send_frame(cur_sync, sltd_pkg::TYPE_READY_ACK, 16'd0, 8'h00, cur_tail); // ack, no payload
    send_frame(cur_sync, sltd_pkg::TYPE_XFER_DONE, 16'd2, sltd_pkg::SUCCESS_BYTE,
               cur_tail);                                                  // done, success
    send_frame(cur_sync, sltd_pkg::TYPE_XFER_DONE, 16'd1, 8'h02, cur_tail); // done, failed
    send_frame(cur_sync, sltd_pkg::TYPE_CANCEL, 16'd3, sltd_pkg::SUCCESS_BYTE, cur_tail);
    send_frame(cur_sync, 8'hFF, 16'd1, 8'hFF, cur_tail);                   // other type
    send_frame(cur_sync, 8'h00, 16'd0, 8'h00, cur_tail);
    // sync prefix that overlaps the real sync word
    for (int i = 0; i < 3; i++) send_byte(cur_sync[31 - 8*i -: 8]);
    send_frame(cur_sync, sltd_pkg::TYPE_XFER_DONE, 16'd4, sltd_pkg::SUCCESS_BYTE, cur_tail);
    // bad tails: first byte wrong, then second byte wrong
    send_frame(cur_sync, sltd_pkg::TYPE_XFER_DONE, 16'd0, 8'h00,
               {sltd_pkg::SUCCESS_BYTE, cur_tail[7:0]});
    send_frame(cur_sync, sltd_pkg::TYPE_READY_ACK, 16'h0100, 8'h00, cur_tail ^ 16'h0001);

    // --- directed, register changes ---
    // tail starting with the success byte: empty payload judged on it
    write_reg(sltd_pkg::REG_TAIL_WORD, {16'hA5A5, sltd_pkg::SUCCESS_BYTE, 8'h00});
    send_frame(cur_sync, sltd_pkg::TYPE_XFER_DONE, 16'd0, 8'h00, cur_tail);
    // tail register rewritten while a frame sits half parsed
    send_head(cur_sync, sltd_pkg::TYPE_XFER_DONE, 16'd2, sltd_pkg::SUCCESS_BYTE);
    write_reg(sltd_pkg::REG_TAIL_WORD, 32'hFFFF_FFFF);
    send_tail(cur_tail);
    // writes past the register list change nothing
    write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_3, 32'h0000_0000);
    send_frame(cur_sync, sltd_pkg::TYPE_CANCEL, 16'd1, 8'h00, cur_tail);
    // all-zero sync right after a frame: an unfilled window must not match
    write_reg(sltd_pkg::REG_SYNC_WORD, 32'h0000_0000);
    send_frame(cur_sync, sltd_pkg::TYPE_READY_ACK, 16'd1, 8'h00, cur_tail);

    // --- random phases, several register settings incl. the extremes ---
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          sw = sltd_pkg::SYNC_WORD_RESET;
          tw = sltd_pkg::TAIL_WORD_RESET;
        end
        1: begin
          sw = 32'hFFFF_FFFF;
          tw = 16'h0000;
        end
        2: begin
          sw = 32'h0000_0000;
          tw = 16'hFFFF;
        end
        default: begin
          sw = $urandom;
          tw = 16'($urandom);
        end
      endcase
      write_reg(sltd_pkg::REG_SYNC_WORD, sw);
      write_reg(sltd_pkg::REG_TAIL_WORD, {16'($urandom), tw});
      random_frames(120);
    end

    // drain, then allow for the output stage
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
